FILE: design/tffa_pkg.sv
package tffa_pkg;

    localparam int FUNC_W      = 2;
    localparam int TYPE_W      = 3;
    localparam int VALUE_W     = 64;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 3;
    localparam int KIND_W      = 3;
    localparam int DATA_W      = 64;
    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 3;
    localparam int NUM_TYPES   = 5;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 3;
    localparam int LEN_W       = 4;

    localparam logic [KIND_W-1:0] TAG_EMPTY = 3'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_REMOVE  = 2'd1,
        FUNC_DISPLAY = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TYPE = 2'd1,
        STATUS_NO_SPACE = 2'd2,
        STATUS_ABSENT   = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic put;
    } tffa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        func_t in_func;
        logic  in_bad_type;
        func_t func;
        logic  scan_done;
        logic  scan_fit;
        logic  write_done;
        logic  out_free;
    } tffa_stat_t;

    // element size in bytes for a type code
    function automatic logic [LEN_W-1:0] type_len(input logic [TYPE_W-1:0] t);
        logic [LEN_W-1:0] len;
        case (t)
            3'd0:    len = 4'd1;
            3'd1:    len = 4'd2;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd8;
            default: len = 4'd1;
        endcase
        return len;
    endfunction

endpackage

FILE: design/tagged_first_fit_byte_allocator.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: func, value; s_tuser: elem_type
// m_       out  m_tvalid/m_tready  m_tdata: status, position, data;
//                                  m_tuser: kind; m_tlast: last
//
// One item is worked at a time; a new item is taken only when the controller is idle.
// The pool is scanned one byte a cycle, save while a full output register holds a
// display scan, through the registered read port of the pool memory, from byte 0.
// Add: find the first free run that fits, write the element's bytes, then the result.
// Remove: free every byte of the type, then the result. Display: emits during the scan.
// A full output register holds the display scan in place; add and remove results wait
// in the result state. Reset (aresetn low, synchronous) marks every byte empty at once.
module tagged_first_fit_byte_allocator #(
    parameter int POOL_BYTES = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] func, [65:2] value, [71:66] zero
    input  logic [tffa_pkg::S_TDATA_W-1:0]     s_tdata,
    // [2:0] elem_type
    input  logic [tffa_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [4:2] position, [68:5] data, [71:69] zero
    output logic [tffa_pkg::M_TDATA_W-1:0]     m_tdata,
    // [2:0] kind
    output logic [tffa_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                               m_tlast
);
    import tffa_pkg::*;

    tffa_cmd_t            cmd;
    tffa_stat_t           stat;
    logic [STATUS_W-1:0]  out_status;
    logic [POS_W-1:0]     out_pos;
    logic [KIND_W-1:0]    out_kind;
    logic [DATA_W-1:0]    out_data;
    logic                 out_last;

    // sequence the operation: idle, scan, write, result
    tffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pool memories, scan pipeline and output register
    tffa_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (func_t'(s_tdata[FUNC_W-1:0])),
        .in_type    (s_tuser[TYPE_W-1:0]),
        .in_value   (s_tdata[FUNC_W +: VALUE_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_pos    (out_pos),
        .out_kind   (out_kind),
        .out_data   (out_data),
        .out_last   (out_last)
    );

    // pack the result item; zero the pad bits
    assign m_tdata = {3'b000, out_data, out_pos, out_status};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

FILE: design/tffa_ctrl.sv
module tffa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  in_ready,
    input  tffa_pkg::tffa_stat_t  stat,
    output tffa_pkg::tffa_cmd_t   cmd
);
    import tffa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (stat.in_func == FUNC_NONE) begin
                        state_next = ST_IDLE;
                    end else if (stat.in_func != FUNC_DISPLAY && stat.in_bad_type) begin
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    if (stat.func == FUNC_ADD && stat.scan_fit) begin
                        state_next = ST_WRITE;
                    end else if (stat.func == FUNC_DISPLAY) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_WRITE: begin
                cmd.write = 1'b1;
                if (stat.write_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                cmd.put = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/tffa_dp.sv
module tffa_dp #(
    parameter int POOL_BYTES = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tffa_pkg::tffa_cmd_t               cmd,
    output tffa_pkg::tffa_stat_t              stat,
    input  tffa_pkg::func_t                   in_func,
    input  logic [tffa_pkg::TYPE_W-1:0]       in_type,
    input  logic [tffa_pkg::VALUE_W-1:0]      in_value,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [tffa_pkg::STATUS_W-1:0]     out_status,
    output logic [tffa_pkg::POS_W-1:0]        out_pos,
    output logic [tffa_pkg::KIND_W-1:0]       out_kind,
    output logic [tffa_pkg::DATA_W-1:0]       out_data,
    output logic                              out_last
);
    import tffa_pkg::*;

    localparam int             AW       = $clog2(POOL_BYTES);
    localparam logic [AW-1:0]  LAST_IDX = AW'(POOL_BYTES - 1);
    localparam logic [AW:0]    DEPTH    = (AW + 1)'(POOL_BYTES);

    // pool storage
    logic [KIND_W-1:0]     tag_mem  [POOL_BYTES];
    logic [7:0]            byte_mem [POOL_BYTES];
    logic [POOL_BYTES-1:0] occ_reg;

    // latched item
    func_t                func_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 bad_reg;

    // read stage
    logic [AW:0]          rd_ptr_reg;
    logic                 pv_reg;
    logic [AW-1:0]        pidx_reg;
    logic [KIND_W-1:0]    tag_q_reg;
    logic [7:0]           byte_q_reg;
    logic                 occ_q_reg;

    // scan state
    logic [2:0]           run_reg;
    logic [AW-1:0]        start_reg;
    logic                 found_reg;
    logic [2:0]           rem_reg;
    logic [2:0]           off_reg;
    logic [AW-1:0]        dstart_reg;
    logic [KIND_W-1:0]    dkind_reg;
    logic [DATA_W-1:0]    dacc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [2:0]           wj_reg;

    // output register
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [POS_W-1:0]     out_pos_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [DATA_W-1:0]    out_data_reg;
    logic                 out_last_reg;

    logic [KIND_W-1:0]    tag_eff;
    logic                 at_end;
    logic                 proc;
    logic [LEN_W-1:0]     cur_len;
    logic                 free_byte;
    logic                 hit;
    logic                 match;
    logic                 elem_open;
    logic                 known_kind;
    logic [LEN_W-1:0]     kind_len;
    logic [DATA_W-1:0]    shifted;
    logic                 d_emit;
    logic                 d_open;
    logic [KIND_W-1:0]    d_kind;
    logic [POS_W-1:0]     d_pos;
    logic [DATA_W-1:0]    d_data;
    logic                 d_last;
    logic                 out_free;
    logic                 stall;
    logic                 adv;
    logic                 issue;
    logic [AW-1:0]        wa;
    status_t              res_status;
    logic [POS_W-1:0]     res_pos;

    assign tag_eff    = occ_q_reg ? tag_q_reg : TAG_EMPTY;
    assign at_end     = (pidx_reg == LAST_IDX);
    assign proc       = cmd.scan && pv_reg;
    assign cur_len    = type_len(type_reg);
    assign free_byte  = (tag_eff == TAG_EMPTY);
    assign hit        = proc && func_reg == FUNC_ADD && free_byte
                        && ({1'b0, run_reg} + 4'd1 == cur_len);
    assign match      = proc && func_reg == FUNC_REMOVE && (tag_eff == type_reg + 3'd1);
    assign elem_open  = (rem_reg != 3'd0);
    assign known_kind = (tag_eff != TAG_EMPTY) && (tag_eff <= KIND_W'(NUM_TYPES));
    assign kind_len   = type_len(tag_eff - 3'd1);
    assign shifted    = {56'd0, byte_q_reg} << {off_reg, 3'b000};
    assign wa         = start_reg + AW'(wj_reg);

    // display: one result per element or empty byte
    always_comb begin
        d_emit = 1'b0;
        d_open = 1'b0;
        d_kind = TAG_EMPTY;
        d_pos  = pidx_reg[POS_W-1:0];
        d_data = '0;
        if (proc && func_reg == FUNC_DISPLAY) begin
            if (elem_open) begin
                d_emit = (rem_reg == 3'd1) || at_end;
                d_kind = dkind_reg;
                d_pos  = dstart_reg[POS_W-1:0];
                d_data = dacc_reg | shifted;
            end else if (!known_kind) begin
                d_emit = 1'b1;
            end else if (kind_len == 4'd1 || at_end) begin
                d_emit = 1'b1;
                d_kind = tag_eff;
                d_data = {56'd0, byte_q_reg};
            end else begin
                d_open = 1'b1;
            end
        end
    end

    assign d_last   = at_end || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign stall    = d_emit && !out_free;
    assign adv      = cmd.scan && !stall;
    assign issue    = adv && (rd_ptr_reg < DEPTH);

    always_comb begin
        if (bad_reg) begin
            res_status = STATUS_BAD_TYPE;
        end else if (func_reg == FUNC_ADD) begin
            res_status = found_reg ? STATUS_OK : STATUS_NO_SPACE;
        end else begin
            res_status = found_reg ? STATUS_OK : STATUS_ABSENT;
        end
    end

    assign res_pos = (func_reg == FUNC_ADD && found_reg) ? start_reg[POS_W-1:0] : '0;

    always_comb begin
        stat             = '0;
        stat.in_func     = in_func;
        stat.in_bad_type = (in_type >= TYPE_W'(NUM_TYPES));
        stat.func        = func_reg;
        stat.scan_fit    = hit;
        stat.scan_done   = (func_reg == FUNC_ADD     && (hit || (proc && at_end)))
                        || (func_reg == FUNC_REMOVE  && proc && at_end)
                        || (func_reg == FUNC_DISPLAY && d_emit && !stall && d_last);
        stat.write_done  = cmd.write && ({1'b0, wj_reg} == cur_len - 4'd1);
        stat.out_free    = out_free;
    end

    // memories: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            byte_mem[wa] <= value_reg[{wj_reg, 3'b000} +: 8];
            tag_mem[wa]  <= type_reg + 3'd1;
        end
        if (issue) begin
            tag_q_reg  <= tag_mem[rd_ptr_reg[AW-1:0]];
            byte_q_reg <= byte_mem[rd_ptr_reg[AW-1:0]];
            occ_q_reg  <= occ_reg[rd_ptr_reg[AW-1:0]];
            pidx_reg   <= rd_ptr_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.write) begin
                occ_reg[wa] <= 1'b1;
            end else if (match) begin
                occ_reg[pidx_reg] <= 1'b0;
            end
            if (cmd.load || !cmd.scan) begin
                pv_reg <= 1'b0;
            end else if (adv) begin
                pv_reg <= issue;
            end
            if ((d_emit && !stall) || cmd.put) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_func;
            type_reg   <= in_type;
            value_reg  <= in_value;
            bad_reg    <= stat.in_bad_type;
            rd_ptr_reg <= '0;
            run_reg    <= '0;
            found_reg  <= 1'b0;
            rem_reg    <= '0;
            off_reg    <= '0;
            cnt_reg    <= '0;
            wj_reg     <= '0;
        end else begin
            if (issue) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (cmd.write) begin
                wj_reg <= wj_reg + 3'd1;
            end
            if (proc && !stall) begin
                case (func_reg)
                    FUNC_ADD: begin
                        if (free_byte) begin
                            if (run_reg == 3'd0) begin
                                start_reg <= pidx_reg;
                            end
                            run_reg <= run_reg + 3'd1;
                            if (hit) begin
                                found_reg <= 1'b1;
                            end
                        end else begin
                            run_reg <= '0;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (match) begin
                            found_reg <= 1'b1;
                        end
                    end
                    FUNC_DISPLAY: begin
                        if (d_open) begin
                            rem_reg    <= 3'(kind_len - 4'd1);
                            off_reg    <= 3'd1;
                            dstart_reg <= pidx_reg;
                            dkind_reg  <= tag_eff;
                            dacc_reg   <= {56'd0, byte_q_reg};
                        end else if (elem_open) begin
                            if (d_emit) begin
                                rem_reg <= '0;
                            end else begin
                                rem_reg  <= rem_reg - 3'd1;
                                off_reg  <= off_reg + 3'd1;
                                dacc_reg <= d_data;
                            end
                        end
                        if (d_emit) begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_emit && !stall) begin
            out_status_reg <= STATUS_OK;
            out_pos_reg    <= d_pos;
            out_kind_reg   <= d_kind;
            out_data_reg   <= d_data;
            out_last_reg   <= d_last;
        end else if (cmd.put) begin
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
            out_kind_reg   <= TAG_EMPTY;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pos    = out_pos_reg;
    assign out_kind   = out_kind_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: design/tffa_checker.sv
module tffa_props (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [tffa_pkg::S_TDATA_W-1:0]     s_tdata,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tffa_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic [tffa_pkg::M_TUSER_W-1:0]     m_tuser,
    input logic                               m_tlast
);
    import tffa_pkg::*;

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result item changed while stalled");

    // any real operation keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] != FUNC_NONE |=> !s_tready)
        else $error("new item taken while one is in work");

    // failures come alone, with no position or kind
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != STATUS_OK |-> m_tlast && m_tdata[4:2] == 3'd0
                                                  && m_tuser == 3'd0)
        else $error("failure result malformed");

    // only display results continue a run, and they are always ok
    a_run_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[1:0] == STATUS_OK && m_tdata[71:69] == 3'd0)
        else $error("non-final result with bad status or pad");

endmodule

bind tagged_first_fit_byte_allocator tffa_props u_tffa_checker (.*);
